// ===== rtl/zsn_pkg.sv =====
package zsn_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int GAIN_W     = 7;
    localparam int CODE_W     = 8;
    localparam int VCNT_W     = 7;   // valid count, sized for the largest vector
    localparam int SUM_W      = 30;  // value sum
    localparam int SQ_W       = 54;  // square sum
    localparam int PROD_W     = 60;  // v * square sum, |sum|^2
    localparam int ROOT_W     = 64;
    localparam int S_W        = 32;  // root after flooring
    localparam int NUM_W      = 41;  // 4 * gain * (v*x - sum)
    localparam int QUO_W      = 30;
    localparam int ITER_W     = 5;

    localparam logic [GAIN_W-1:0] GAIN_RST = 7'd32;

    localparam logic [ITER_W-1:0] MULA_LAST = 5'd6;   // seven shift-add steps
    localparam logic [ITER_W-1:0] SQRT_LAST = 5'd31;  // one result bit per step
    localparam logic [ITER_W-1:0] MEAN_LAST = 5'd29;  // thirty quotient bits
    localparam logic [ITER_W-1:0] CODE_LAST = 5'd7;   // eight quotient bits

    typedef struct packed {
        logic load;       // write one element and update the sums unless it is missing
        logic clear;      // drop the sums for the next vector
        logic mula_init;
        logic mula_step;
        logic diff;       // form the variance term and seed the root
        logic sqrt_step;
        logic mdiv_init;
        logic ediv_init;
        logic div_step;
        logic mean_take;
        logic mul1;
        logic mul2;
        logic emit;
        logic last;
    } t_cmd;

endpackage

// ===== rtl/zsn_ram.sv =====
module zsn_ram #(
    parameter int WIDTH = 25,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/zsn_ctrl.sv =====
module zsn_ctrl #(
    parameter int VEC_LEN = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic                       i_last_in,
    output logic                       o_busy,
    output logic [$clog2(VEC_LEN)-1:0] o_waddr,
    output logic [$clog2(VEC_LEN)-1:0] o_raddr,
    output zsn_pkg::t_cmd              o_cmd
);

    localparam int AW = $clog2(VEC_LEN);
    localparam int CW = $clog2(VEC_LEN + 1);
    localparam logic [CW-1:0] FULL = CW'(VEC_LEN);

    typedef enum logic [13:0] {
        S_LOAD  = 14'b00000000000001,
        S_MINIT = 14'b00000000000010,
        S_MULA  = 14'b00000000000100,
        S_DIFF  = 14'b00000000001000,
        S_SQRT  = 14'b00000000010000,
        S_MDIV  = 14'b00000000100000,
        S_MEAN  = 14'b00000001000000,
        S_MTAKE = 14'b00000010000000,
        S_RD    = 14'b00000100000000,
        S_MUL1  = 14'b00001000000000,
        S_MUL2  = 14'b00010000000000,
        S_PREP  = 14'b00100000000000,
        S_DIV   = 14'b01000000000000,
        S_EMIT  = 14'b10000000000000
    } t_state;

    t_state                      r_state, n_state;
    logic [CW-1:0]               r_count, n_count;
    logic [AW-1:0]               r_idx, n_idx;
    logic [zsn_pkg::ITER_W-1:0]  r_iter, n_iter;
    logic                        is_last;

    assign is_last = (CW'({1'b0, r_idx}) + CW'(1)) == r_count;

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_idx   = r_idx;
        n_iter  = r_iter;
        o_cmd   = '0;
        case (r_state)
            S_LOAD: begin
                if (i_start) begin
                    if (r_count < FULL) begin
                        o_cmd.load = 1'b1;
                        n_count    = r_count + CW'(1);
                    end
                    if (i_last_in) begin
                        n_state = S_MINIT;
                    end
                end
            end
            S_MINIT: begin
                o_cmd.mula_init = 1'b1;
                n_iter  = '0;
                n_state = S_MULA;
            end
            S_MULA: begin
                o_cmd.mula_step = 1'b1;
                n_iter = r_iter + 1'b1;
                if (r_iter == zsn_pkg::MULA_LAST) begin
                    n_state = S_DIFF;
                end
            end
            S_DIFF: begin
                o_cmd.diff = 1'b1;
                n_iter  = '0;
                n_state = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                n_iter = r_iter + 1'b1;
                if (r_iter == zsn_pkg::SQRT_LAST) begin
                    n_state = S_MDIV;
                end
            end
            S_MDIV: begin
                o_cmd.mdiv_init = 1'b1;
                n_iter  = '0;
                n_state = S_MEAN;
            end
            S_MEAN: begin
                o_cmd.div_step = 1'b1;
                n_iter = r_iter + 1'b1;
                if (r_iter == zsn_pkg::MEAN_LAST) begin
                    n_state = S_MTAKE;
                end
            end
            S_MTAKE: begin
                o_cmd.mean_take = 1'b1;
                n_idx   = '0;
                n_state = S_RD;
            end
            S_RD: begin
                n_state = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state = S_PREP;
            end
            S_PREP: begin
                o_cmd.ediv_init = 1'b1;
                n_iter  = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_iter = r_iter + 1'b1;
                if (r_iter == zsn_pkg::CODE_LAST) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                o_cmd.last = is_last;
                if (is_last) begin
                    o_cmd.clear = 1'b1;
                    n_count = '0;
                    n_state = S_LOAD;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_RD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_idx   <= '0;
            r_iter  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_iter  <= n_iter;
        end
    end

    assign o_busy  = (r_state != S_LOAD);
    assign o_waddr = r_count[AW-1:0];
    assign o_raddr = r_idx;

endmodule

// ===== rtl/zsn_dp.sv =====
module zsn_dp #(
    parameter int VEC_LEN = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  zsn_pkg::t_cmd                       i_cmd,
    input  logic [$clog2(VEC_LEN)-1:0]          i_waddr,
    input  logic [$clog2(VEC_LEN)-1:0]          i_raddr,
    input  logic signed [zsn_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                i_missing,
    input  logic                                i_cfg_we,
    input  logic [zsn_pkg::GAIN_W-1:0]          i_cfg_wdata,
    output logic                                o_valid,
    output logic signed [zsn_pkg::CODE_W-1:0]   o_code,
    output logic signed [zsn_pkg::SAMPLE_W-1:0] o_vector_mean,
    output logic                                o_last_out
);

    localparam int XW  = zsn_pkg::SAMPLE_W;
    localparam int MW  = XW + 1;

    // configuration and per-vector statistics
    logic [zsn_pkg::GAIN_W-1:0]       r_gain;
    logic [zsn_pkg::VCNT_W-1:0]       r_v;
    logic signed [zsn_pkg::SUM_W-1:0] r_s1;
    logic [zsn_pkg::SQ_W-1:0]         r_s2;

    // variance and root
    logic [zsn_pkg::PROD_W-1:0]       r_acc, r_mcand, r_b;
    logic [zsn_pkg::VCNT_W-1:0]       r_mplier;
    logic [zsn_pkg::ROOT_W-1:0]       r_sn, r_root, r_bit;
    logic                             r_vzero;

    // shared divider
    logic [zsn_pkg::S_W-1:0]          r_rem, r_div;
    logic [zsn_pkg::QUO_W-1:0]        r_low, r_quo;

    // element path
    logic signed [31:0]               r_p1;
    logic signed [zsn_pkg::NUM_W-1:0] r_num;
    logic                             r_miss, r_sat, r_neg;
    logic [XW-1:0]                    r_mean;

    // output beat
    logic                             r_valid;
    logic signed [zsn_pkg::CODE_W-1:0] r_code;
    logic                             r_last;

    logic [MW-1:0]                    ram_rdata;
    logic signed [2*XW-1:0]           sq;
    logic [zsn_pkg::SUM_W-1:0]        s1_mag;
    logic [zsn_pkg::PROD_W-1:0]       d;
    logic [zsn_pkg::ROOT_W-1:0]       root_try;
    logic [zsn_pkg::S_W-1:0]          s_floor;
    logic [zsn_pkg::S_W:0]            div_try;
    logic signed [31:0]               vx, v_s, x_s;
    logic signed [zsn_pkg::NUM_W-1:0] num_w, p1_w, g_w;
    logic [zsn_pkg::NUM_W-1:0]        mag, mag_r;
    logic [7:0]                       q8;
    logic signed [zsn_pkg::CODE_W-1:0] code_w;
    logic [XW-1:0]                    mean_w;

    zsn_ram #(
        .WIDTH (MW),
        .DEPTH (VEC_LEN)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load),
        .i_waddr (i_waddr),
        .i_wdata ({i_missing, i_sample}),
        .i_raddr (i_raddr),
        .o_rdata (ram_rdata)
    );

    assign sq       = i_sample * i_sample;
    assign s1_mag   = r_s1[zsn_pkg::SUM_W-1] ? zsn_pkg::SUM_W'(-r_s1) : zsn_pkg::SUM_W'(r_s1);
    assign d        = (r_acc > r_b) ? (r_acc - r_b) : '0;
    assign root_try = r_root + r_bit;
    assign s_floor  = (r_root[zsn_pkg::S_W-1:0] == '0) ? zsn_pkg::S_W'(1)
                                                         : r_root[zsn_pkg::S_W-1:0];
    assign div_try  = {r_rem, r_low[zsn_pkg::QUO_W-1]};

    assign v_s   = {{(32 - zsn_pkg::VCNT_W){1'b0}}, r_v};
    assign x_s   = {{(32 - XW){ram_rdata[XW-1]}}, ram_rdata[XW-1:0]};
    assign vx    = v_s * x_s;
    assign p1_w  = {{(zsn_pkg::NUM_W - 32){r_p1[31]}}, r_p1};
    assign g_w   = {{(zsn_pkg::NUM_W - zsn_pkg::GAIN_W){1'b0}}, r_gain};
    assign num_w = p1_w * g_w;
    assign mag   = r_num[zsn_pkg::NUM_W-1] ? zsn_pkg::NUM_W'(-r_num)
                                           : zsn_pkg::NUM_W'(r_num);
    assign mag_r = mag + {{(zsn_pkg::NUM_W - zsn_pkg::S_W){1'b0}}, s_floor >> 1};

    assign q8 = r_quo[7:0];

    always_comb begin
        if (r_miss || r_vzero) begin
            code_w = '0;
        end else if (!r_neg) begin
            code_w = (r_sat || q8 > 8'd127) ? 8'sd127 : $signed(q8);
        end else begin
            code_w = (r_sat || q8 > 8'd128) ? -8'sd128 : $signed(8'(-q8));
        end
    end

    assign mean_w = r_vzero ? '0
                  : (r_s1[zsn_pkg::SUM_W-1] ? XW'(-r_quo) : r_quo[XW-1:0]);

    // control state: gain, sums, output strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain  <= zsn_pkg::GAIN_RST;
            r_v     <= '0;
            r_s1    <= '0;
            r_s2    <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_gain <= i_cfg_wdata;
            end
            if (i_cmd.clear) begin
                r_v  <= '0;
                r_s1 <= '0;
                r_s2 <= '0;
            end else if (i_cmd.load && !i_missing) begin
                r_v  <= r_v + 1'b1;
                r_s1 <= r_s1 + zsn_pkg::SUM_W'(i_sample);
                r_s2 <= r_s2 + zsn_pkg::SQ_W'(sq[2*XW-2:0]);
            end
            r_valid <= i_cmd.emit;
        end
    end

    // arithmetic payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.mula_init) begin
            r_acc    <= '0;
            r_mcand  <= zsn_pkg::PROD_W'(r_s2);
            r_mplier <= r_v;
            r_b      <= zsn_pkg::PROD_W'(s1_mag) * zsn_pkg::PROD_W'(s1_mag);
        end
        if (i_cmd.mula_step) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand  <= r_mcand << 1;
            r_mplier <= r_mplier >> 1;
        end
        if (i_cmd.diff) begin
            r_sn    <= {d[zsn_pkg::PROD_W-1:0], 4'b0000};
            r_root  <= '0;
            r_bit   <= zsn_pkg::ROOT_W'(1) << (zsn_pkg::ROOT_W - 2);
            r_vzero <= (r_v == '0);
        end
        if (i_cmd.sqrt_step) begin
            if (r_sn >= root_try) begin
                r_sn   <= r_sn - root_try;
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (i_cmd.mdiv_init) begin
            r_rem <= '0;
            r_div <= zsn_pkg::S_W'(r_v);
            r_low <= s1_mag + zsn_pkg::SUM_W'(r_v[zsn_pkg::VCNT_W-1:1]);
            r_quo <= '0;
        end
        if (i_cmd.mul1) begin
            r_p1   <= vx - 32'(r_s1);
            r_miss <= ram_rdata[XW];
        end
        if (i_cmd.mul2) begin
            r_num <= num_w <<< 2;
        end
        if (i_cmd.ediv_init) begin
            r_neg <= r_num[zsn_pkg::NUM_W-1];
            r_sat <= mag_r >= {1'b0, s_floor, 8'h00};
            r_rem <= mag_r[zsn_pkg::S_W+7:8];
            r_low <= {mag_r[7:0], {(zsn_pkg::QUO_W - 8){1'b0}}};
            r_div <= s_floor;
            r_quo <= '0;
        end
        if (i_cmd.div_step) begin
            if (div_try >= {1'b0, r_div}) begin
                r_rem <= zsn_pkg::S_W'(div_try - {1'b0, r_div});
                r_quo <= {r_quo[zsn_pkg::QUO_W-2:0], 1'b1};
            end else begin
                r_rem <= div_try[zsn_pkg::S_W-1:0];
                r_quo <= {r_quo[zsn_pkg::QUO_W-2:0], 1'b0};
            end
            r_low <= r_low << 1;
        end
        if (i_cmd.mean_take) begin
            r_mean <= mean_w;
        end
        if (i_cmd.emit) begin
            r_code <= code_w;
            r_last <= i_cmd.last;
        end
    end

    assign o_valid       = r_valid;
    assign o_code        = r_code;
    assign o_vector_mean = r_mean;
    assign o_last_out    = r_last;

endmodule

// ===== rtl/zscore_normalize_to_int8.sv =====
// Z-score standardization of one vector to signed 8-bit codes.
//
// Input channel: present i_sample (Q15.8), i_missing and i_last_in with start;
// a beat is taken at each edge where start is high and busy is low. While a
// vector loads, busy stays low and one element is taken every cycle. Up to
// VEC_LEN elements are stored; extra ones are dropped, but a last flag on them
// still closes the vector.
// After the last beat the block computes the variance term with a 7-step
// shift-add multiplier, a 32-step integer square root and a 30-step divider
// for the mean. It then emits one code per stored element, each through a RAM
// read, two multiply stages, setup, 8 divider steps and the emit, bounded by
// the single shared divider. busy is high from the cycle after the last beat
// until the final code is issued. Output channel: o_valid marks each result
// beat for exactly one cycle; the receiver cannot stall, so every beat must
// be taken when shown. Configuration: i_cfg_we writes the gain; the user must
// do so only while the block is idle, which the block itself does not enforce.
// Reset (i_rst_n low, synchronous) sets gain to 32 and clears the sums.
module zscore_normalize_to_int8 #(
    parameter int VEC_LEN = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [zsn_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                i_missing,
    input  logic                                i_last_in,
    input  logic                                i_cfg_we,
    input  logic [zsn_pkg::GAIN_W-1:0]          i_cfg_wdata,
    output logic                                o_valid,
    output logic signed [zsn_pkg::CODE_W-1:0]   o_code,
    output logic signed [zsn_pkg::SAMPLE_W-1:0] o_vector_mean,
    output logic                                o_last_out
);

    localparam int AW = $clog2(VEC_LEN);

    zsn_pkg::t_cmd cmd;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;

    // sequence the load, statistics and emit phases
    zsn_ctrl #(
        .VEC_LEN (VEC_LEN)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_last_in (i_last_in),
        .o_busy    (busy),
        .o_waddr   (waddr),
        .o_raddr   (raddr),
        .o_cmd     (cmd)
    );

    // hold the store, sums, root and divider
    zsn_dp #(
        .VEC_LEN (VEC_LEN)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_waddr       (waddr),
        .i_raddr       (raddr),
        .i_sample      (i_sample),
        .i_missing     (i_missing),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_valid       (o_valid),
        .o_code        (o_code),
        .o_vector_mean (o_vector_mean),
        .o_last_out    (o_last_out)
    );

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int VLEN       = 64;
    localparam int STALL_MAX  = 20000;   // cycles with no beat before giving up
    localparam int DRAIN_WAIT = 40;

    // Result of one emitted element.
    typedef struct {
        logic signed [zsn_pkg::CODE_W-1:0]   code;
        logic signed [zsn_pkg::SAMPLE_W-1:0] mean;
        logic                                last;
    } t_zcode;

    // One row of the directed table; chk_* holds a hand-read expectation.
    typedef struct {
        logic signed [zsn_pkg::SAMPLE_W-1:0] sample;
        logic                                missing;
        logic                                last_in;
        logic                                has_chk;
        logic signed [zsn_pkg::CODE_W-1:0]   chk_code;
        logic signed [zsn_pkg::SAMPLE_W-1:0] chk_mean;
    } t_row;

    logic                                 i_clk;
    logic                                 i_rst_n;
    logic                                 start;
    logic                                 busy;
    logic signed [zsn_pkg::SAMPLE_W-1:0]  i_sample;
    logic                                 i_missing;
    logic                                 i_last_in;
    logic                                 i_cfg_we;
    logic [zsn_pkg::GAIN_W-1:0]           i_cfg_wdata;
    logic                                 o_valid;
    logic signed [zsn_pkg::CODE_W-1:0]    o_code;
    logic signed [zsn_pkg::SAMPLE_W-1:0]  o_vector_mean;
    logic                                 o_last_out;

    zscore_normalize_to_int8 #(.VEC_LEN(VLEN)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_sample(i_sample), .i_missing(i_missing), .i_last_in(i_last_in),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .o_valid(o_valid), .o_code(o_code), .o_vector_mean(o_vector_mean),
        .o_last_out(o_last_out)
    );

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Predictor state: a shadow of the block's store, sums and gain.
    logic [zsn_pkg::GAIN_W-1:0]           gain_q;
    logic signed [zsn_pkg::SAMPLE_W-1:0]  elem_q [VLEN];
    logic                                 miss_q [VLEN];
    int unsigned                          n_elem;
    int unsigned                          n_valid;
    longint                               sum_x;
    longint unsigned                      sum_xx;

    t_zcode code_fifo[$];
    int     n_err;
    int     idle_cnt;
    bit     busy_idle;   // true: sender inserts random gaps

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Divide rounding to nearest, ties away from zero; den is positive.
    function automatic longint round_div(longint num, longint den);
        longint unsigned m, q;
        m = (num < 0) ? -num : num;
        q = (m + den / 2) / den;
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    // Absorb one beat into the vector; on the last one queue all its codes.
    task automatic predict_zcodes(input logic signed [zsn_pkg::SAMPLE_W-1:0] x,
                                  input logic miss, input logic lst);
        longint          mean, num, c, xv;
        longint unsigned s, mag, d;
        t_zcode          r;
        mean = 0;
        s = 1;
        xv = x;
        if (n_elem < VLEN) begin
            elem_q[n_elem] = x;
            miss_q[n_elem] = miss;
            n_elem++;
            if (!miss) begin
                n_valid++;
                sum_x += xv;
                sum_xx += longint'(xv * xv);
            end
        end
        if (!lst) return;
        if (n_valid > 0) begin
            mag = (sum_x < 0) ? -sum_x : sum_x;
            d = (n_valid * sum_xx > mag * mag) ? n_valid * sum_xx - mag * mag : 0;
            mean = round_div(sum_x, n_valid);
            s = int_sqrt(d << 4);
            if (s == 0) s = 1;
        end
        for (int k = 0; k < n_elem; k++) begin
            c = 0;
            if (n_valid > 0 && !miss_q[k]) begin
                num = (longint'(n_valid) * longint'(elem_q[k]) - sum_x) * 4
                      * longint'(gain_q);
                c = round_div(num, s);
                if (c > 127) c = 127;
                if (c < -128) c = -128;
            end
            r.code = c[zsn_pkg::CODE_W-1:0];
            r.mean = mean[zsn_pkg::SAMPLE_W-1:0];
            r.last = (k + 1 == n_elem);
            code_fifo = {code_fifo, r};
        end
        n_elem = 0;
        n_valid = 0;
        sum_x = 0;
        sum_xx = 0;
    endtask

    // Check every result beat against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            t_zcode e;
            if (code_fifo.size() == 0) begin
                $error("unexpected result beat code=%0d", o_code);
                n_err++;
            end else begin
                e = code_fifo.pop_front();
                if (o_code !== e.code) begin
                    $error("code: expected %0d, got %0d", e.code, o_code);
                    n_err++;
                end
                if (o_vector_mean !== e.mean) begin
                    $error("vector_mean: expected %0d, got %0d", e.mean, o_vector_mean);
                    n_err++;
                end
                if (o_last_out !== e.last) begin
                    $error("last_out: expected %0d, got %0d", e.last, o_last_out);
                    n_err++;
                end
            end
        end
    end

    // Watchdog: count cycles in which no beat moves either way.
    always @(posedge i_clk) begin
        if (!i_rst_n || o_valid || (start && !busy)) begin
            idle_cnt <= 0;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
        if (idle_cnt > STALL_MAX) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Present one beat at the falling edge and hold it until taken; start stays
    // high afterwards so the next beat can follow back to back.
    task automatic send_beat(input logic signed [zsn_pkg::SAMPLE_W-1:0] x,
                             input logic miss, input logic lst);
        while (busy_idle && $urandom_range(99) < 37) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start     <= 1'b1;
        i_sample  <= x;
        i_missing <= miss;
        i_last_in <= lst;
        do @(posedge i_clk); while (busy);
        predict_zcodes(x, miss, lst);
        @(negedge i_clk);
    endtask

    // Wait for every result, then past any trailing work, before touching gain.
    task automatic drain_all();
        start <= 1'b0;
        while (code_fifo.size() != 0 || busy) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic write_gain(input logic [zsn_pkg::GAIN_W-1:0] g);
        drain_all();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= g;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        gain_q = g;
    endtask

    // Random vector: mostly small lengths, now and then near full or overfull.
    task automatic send_vector();
        int len, pick, mode;
        logic signed [zsn_pkg::SAMPLE_W-1:0] x, base;
        pick = $urandom_range(99);
        if (pick < 80)      len = $urandom_range(1, 8);
        else if (pick < 95) len = $urandom_range(9, 24);
        else                len = $urandom_range(60, 70);
        mode = $urandom_range(3);
        base = zsn_pkg::SAMPLE_W'($urandom);
        for (int k = 0; k < len; k++) begin
            case (mode)
                0: x = zsn_pkg::SAMPLE_W'($urandom);              // full range
                1: x = zsn_pkg::SAMPLE_W'(base + $signed($urandom_range(0, 63)) - 32);
                2: x = ($urandom_range(1)) ? 24'sh7FFFFF : 24'sh800000;
                default: x = zsn_pkg::SAMPLE_W'($signed($urandom_range(0, 2047)) - 1024);
            endcase
            send_beat(x, ($urandom_range(99) < 15), (k == len - 1));
        end
    endtask

    t_row   rows[$];
    t_zcode got_hand;

    initial begin
        logic [zsn_pkg::GAIN_W-1:0] g;
        n_err = 0;
        idle_cnt = 0;
        gain_q = zsn_pkg::GAIN_RST;
        n_elem = 0;
        n_valid = 0;
        sum_x = 0;
        sum_xx = 0;
        busy_idle = 1'b0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_sample = '0;
        i_missing = 1'b0;
        i_last_in = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed rows. Hand values: a lone sample has zero spread so its code
        // is 0 and the mean is itself; an all-missing vector gives 0 and 0.
        rows = '{
            '{24'sh7FFFFF, 1'b0, 1'b1, 1'b1, 8'sd0,  24'sh7FFFFF},
            '{24'sh800000, 1'b0, 1'b1, 1'b1, 8'sd0,  24'sh800000},
            '{24'sh000123, 1'b1, 1'b0, 1'b0, 8'sd0,  24'sd0},
            '{24'sh7FFFFF, 1'b1, 1'b1, 1'b1, 8'sd0,  24'sd0},
            '{24'sh800000, 1'b0, 1'b0, 1'b0, 8'sd0,  24'sd0},
            '{24'sh7FFFFF, 1'b0, 1'b1, 1'b0, 8'sd0,  24'sd0},
            '{24'sh000100, 1'b0, 1'b0, 1'b0, 8'sd0,  24'sd0},
            '{24'sh000200, 1'b1, 1'b0, 1'b0, 8'sd0,  24'sd0},
            '{24'sh000300, 1'b0, 1'b1, 1'b0, 8'sd0,  24'sd0},
            '{24'sh555555, 1'b0, 1'b0, 1'b0, 8'sd0,  24'sd0},
            '{24'shAAAAAA, 1'b0, 1'b1, 1'b0, 8'sd0,  24'sd0}
        };
        foreach (rows[i]) begin
            send_beat(rows[i].sample, rows[i].missing, rows[i].last_in);
            if (rows[i].has_chk) begin
                got_hand = code_fifo[code_fifo.size() - 1];
                if (got_hand.code !== rows[i].chk_code || got_hand.mean !== rows[i].chk_mean) begin
                    $error("table row %0d: predictor disagrees with hand value", i);
                    n_err++;
                end
            end
        end

        // Overfull vector at the top gain (70 beats, only 64 stored), then short vectors at gains 1 and 0.
        write_gain(7'd127);
        for (int k = 0; k < 70; k++)
            send_beat((k % 2) ? 24'sh7FFFFF : 24'sh800000, (k == 3), (k == 69));
        write_gain(7'd1);
        for (int k = 0; k < 4; k++)
            send_beat(zsn_pkg::SAMPLE_W'(k * 32'sh010000), 1'b0, (k == 3));
        write_gain(7'd0);
        for (int k = 0; k < 3; k++)
            send_beat(zsn_pkg::SAMPLE_W'($urandom), 1'b0, (k == 2));

        // Random part: first a burst with no gaps, then gaps with gain changes.
        for (int v = 0; v < 24; v++) begin
            if (v == 10) busy_idle = 1'b1;
            if (v % 12 == 11) begin
                g = zsn_pkg::GAIN_W'($urandom_range(1, 127));
                write_gain(g);
            end
            send_vector();
        end

        drain_all();
        if (n_err == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
